// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the light barrier RTL.
// Each macro expects signals named clk and arst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define LBDT_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define LBDT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/lbdt_pkg.sv -----
// Types and constants for the light barrier delayed trigger.
// No dependencies; used by the interfaces and every module.
package lbdt_pkg;

	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned WINDOW_W = 10;
	localparam int unsigned DELAY_W = 14;
	localparam int unsigned PULSE_W = 8;
	localparam int unsigned HOLDOFF_W = 16;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [WINDOW_W-1:0] WINDOW_RST = 10'd50;
	localparam logic [DELAY_W-1:0] DELAY_RST = 14'd150;
	localparam logic [PULSE_W-1:0] PULSE_RST = 8'd8;
	localparam logic [HOLDOFF_W-1:0] HOLDOFF_RST = 16'd2000;

	typedef enum logic [1:0] {
		CMD_TICK = 2'd0,
		CMD_SAMPLE = 2'd1,
		CMD_ARM = 2'd2,
		CMD_NOP = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RC_NONE = 2'd0,
		RC_START = 2'd1,
		RC_PAUSE = 2'd2,
		RC_STOP = 2'd3
	} rc_t;

	typedef enum logic [2:0] {
		MODE_IDLE = 3'd0,
		MODE_CAL = 3'd1,
		MODE_ARMED = 3'd2,
		MODE_DELAY = 3'd3,
		MODE_FIRE = 3'd4
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW = 2'd0,
		REG_DELAY = 2'd1,
		REG_PULSE = 2'd2,
		REG_HOLDOFF = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [WINDOW_W-1:0] window;
		logic [DELAY_W-1:0] trigger_delay_ms;
		logic [PULSE_W-1:0] pulse_ms;
		logic [HOLDOFF_W-1:0] holdoff_ms;
	} cfg_t;

	typedef struct packed {
		logic shutter;
		rc_t remote_cmd;
		mode_t phase;
		logic [SAMPLE_W-1:0] baseline_out;
	} res_t;

endpackage

// ----- hw/rtl/lbdt_if.sv -----
// Valid/ready channel interfaces for input items and result items.
// Depends on lbdt_pkg for field widths.
interface lbdt_in_if import lbdt_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [SAMPLE_W-1:0] sample;

	modport source (output valid, output cmd, output sample, input ready);
	modport sink (input valid, input cmd, input sample, output ready);
endinterface

interface lbdt_out_if import lbdt_pkg::*; ();
	logic valid;
	logic ready;
	logic shutter;
	logic [1:0] remote_cmd;
	logic [2:0] phase;
	logic [SAMPLE_W-1:0] baseline_out;

	modport source (output valid, output shutter, output remote_cmd, output phase,
		output baseline_out, input ready);
	modport sink (input valid, input shutter, input remote_cmd, input phase,
		input baseline_out, output ready);
endinterface

// ----- hw/rtl/lbdt_fsm.sv -----
// Sequencer state of the light barrier: mode, baseline, countdown and pulse.
// Steps once per item when step_en is high. Depends on lbdt_pkg, assert_macros.svh.
`include "assert_macros.svh"

module lbdt_fsm import lbdt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic step_en,
	input cmd_t cmd,
	input logic [SAMPLE_W-1:0] sample,
	input cfg_t cfg,
	output res_t res
);

	mode_t mode_q, mode_d;
	logic [SAMPLE_W-1:0] baseline_q, baseline_d;
	logic [SAMPLE_W-1:0] last_sample_q, last_sample_d;
	logic [COUNT_W-1:0] countdown_q, countdown_d;
	logic in_pulse_q, in_pulse_d;
	rc_t rc;

	// Band limits in signed arithmetic so that baseline minus window cannot wrap.
	logic signed [SAMPLE_W+1:0] v_sx, lo_sx, hi_sx;
	logic hit;
	logic cd_more;
	logic holdoff_zero;
	logic delay_zero;

	assign v_sx = $signed({2'b00, sample});
	assign lo_sx = $signed({2'b00, baseline_q}) - $signed({2'b00, cfg.window});
	assign hi_sx = $signed({2'b00, baseline_q}) + $signed({2'b00, cfg.window});
	assign hit = (v_sx <= lo_sx) || (v_sx >= hi_sx);
	assign cd_more = countdown_q > COUNT_W'(1);
	assign holdoff_zero = cfg.holdoff_ms == '0;
	assign delay_zero = cfg.trigger_delay_ms == '0;

	// Next state.
	always_comb begin
		mode_d = mode_q;
		baseline_d = baseline_q;
		last_sample_d = last_sample_q;
		countdown_d = countdown_q;
		in_pulse_d = in_pulse_q;
		unique case (cmd)
			CMD_ARM: begin
				if (mode_q == MODE_IDLE) begin
					mode_d = MODE_CAL;
				end
			end
			CMD_SAMPLE: begin
				last_sample_d = sample;
				if (mode_q == MODE_CAL) begin
					if (sample == last_sample_q) begin
						baseline_d = sample;
						mode_d = MODE_ARMED;
					end
				end else if (mode_q == MODE_ARMED && hit) begin
					if (delay_zero) begin
						mode_d = MODE_FIRE;
						in_pulse_d = 1'b1;
						countdown_d = COUNT_W'(cfg.pulse_ms);
					end else begin
						mode_d = MODE_DELAY;
						countdown_d = COUNT_W'(cfg.trigger_delay_ms);
					end
				end
			end
			CMD_TICK: begin
				if (mode_q == MODE_DELAY) begin
					if (cd_more) begin
						countdown_d = countdown_q - COUNT_W'(1);
					end else begin
						mode_d = MODE_FIRE;
						in_pulse_d = 1'b1;
						countdown_d = COUNT_W'(cfg.pulse_ms);
					end
				end else if (mode_q == MODE_FIRE) begin
					if (cd_more) begin
						countdown_d = countdown_q - COUNT_W'(1);
					end else if (in_pulse_q) begin
						in_pulse_d = 1'b0;
						countdown_d = cfg.holdoff_ms;
						if (holdoff_zero) begin
							mode_d = MODE_IDLE;
						end
					end else begin
						countdown_d = '0;
						mode_d = MODE_IDLE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Remote command sent by this item.
	always_comb begin
		rc = RC_NONE;
		unique case (cmd)
			CMD_ARM: begin
				if (mode_q == MODE_IDLE) begin
					rc = RC_START;
				end
			end
			CMD_SAMPLE: begin
				if (mode_q == MODE_ARMED && hit) begin
					rc = RC_PAUSE;
				end
			end
			CMD_TICK: begin
				if (mode_q == MODE_FIRE && !cd_more && (!in_pulse_q || holdoff_zero)) begin
					rc = RC_STOP;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		res.shutter = in_pulse_d;
		res.remote_cmd = rc;
		res.phase = mode_d;
		res.baseline_out = baseline_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			baseline_q <= '0;
			last_sample_q <= '0;
			countdown_q <= '0;
			in_pulse_q <= 1'b0;
		end else if (step_en) begin
			mode_q <= mode_d;
			baseline_q <= baseline_d;
			last_sample_q <= last_sample_d;
			countdown_q <= countdown_d;
			in_pulse_q <= in_pulse_d;
		end
	end

	`LBDT_ASSERT(a_pulse_in_fire, in_pulse_q |-> (mode_q == MODE_FIRE), "pulse outside fire phase")
	`LBDT_NEVER(a_delay_cd_zero, (mode_q == MODE_DELAY) && (countdown_q == '0), "delay with empty countdown")
	`LBDT_ASSERT(a_arm_busy, (step_en && cmd == CMD_ARM && mode_q != MODE_IDLE) |=> $stable(mode_q), "arm request changed a busy block")

endmodule

// ----- hw/rtl/light_barrier_delayed_trigger.sv -----
// Light barrier with delayed camera trigger.
// Channels: in_ch carries items (cmd: tick, sample, arm request or no-op,
// plus a light sample); out_ch returns one result item per input item with the
// shutter level, the remote command sent, the phase and the baseline.
// Configuration: cfg_we writes cfg_data into register cfg_idx (window,
// trigger delay, pulse length, holdoff) at the clock edge; write only while
// no item is in flight.
// Timing: an accepted item waits in the input register; as it leaves, the
// sequencer steps and the result register loads, and out_ch.valid rises.
// Throughput: one item per cycle while out_ch is ready; the sequencer state
// updates as the item leaves the input register.
// Stall: when the result register is full and out_ch is not ready, it holds;
// an empty input register still takes one more item, and in_ch.ready stays
// low while the input register is full.
// Reset: arst_n clears both registers' valid flags, returns the sequencer
// to idle with baseline and countdown zero and reloads the register defaults.
// Depends on lbdt_pkg, lbdt_if and lbdt_fsm.
module light_barrier_delayed_trigger import lbdt_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_data,
	lbdt_in_if.sink in_ch,
	lbdt_out_if.source out_ch
);

	cfg_t cfg_q;
	logic valid_s1;
	cmd_t cmd_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic valid_s2;
	res_t res_s2;
	res_t res;
	logic adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window <= WINDOW_RST;
			cfg_q.trigger_delay_ms <= DELAY_RST;
			cfg_q.pulse_ms <= PULSE_RST;
			cfg_q.holdoff_ms <= HOLDOFF_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_WINDOW: cfg_q.window <= cfg_data[WINDOW_W-1:0];
				REG_DELAY: cfg_q.trigger_delay_ms <= cfg_data[DELAY_W-1:0];
				REG_PULSE: cfg_q.pulse_ms <= cfg_data[PULSE_W-1:0];
				REG_HOLDOFF: cfg_q.holdoff_ms <= cfg_data[HOLDOFF_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign adv = valid_s1 && (!valid_s2 || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ch.ready) begin
				valid_s1 <= in_ch.valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			cmd_s1 <= cmd_t'(in_ch.cmd);
			sample_s1 <= in_ch.sample;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	lbdt_fsm u_fsm (
		.clk (clk),
		.arst_n (arst_n),
		.step_en (adv),
		.cmd (cmd_s1),
		.sample (sample_s1),
		.cfg (cfg_q),
		.res (res)
	);

	assign out_ch.valid = valid_s2;
	assign out_ch.shutter = res_s2.shutter;
	assign out_ch.remote_cmd = res_s2.remote_cmd;
	assign out_ch.phase = res_s2.phase;
	assign out_ch.baseline_out = res_s2.baseline_out;

endmodule

// ----- bench/tb_light_barrier_delayed_trigger.sv -----
// Self-checking testbench for light_barrier_delayed_trigger: directed rows, then random
// arm/calibrate/detect/countdown sequences with random idling on both channels.
// Depends on lbdt_pkg, the lbdt_in_if/lbdt_out_if interfaces and the block itself.
module tb_light_barrier_delayed_trigger;
	import lbdt_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 100;

	typedef struct {
		bit is_reg;
		reg_idx_t idx;
		logic [CFG_DATA_W-1:0] data;
		cmd_t cmd;
		logic [SAMPLE_W-1:0] sample;
		bit typed;
		res_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	lbdt_in_if in_ch();
	lbdt_out_if out_ch();

	light_barrier_delayed_trigger dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #5 clk = ~clk;

	// Predicted sequencer state and register copy
	cfg_t cfg;
	mode_t bar_mode;
	logic [SAMPLE_W-1:0] bar_base;
	logic [SAMPLE_W-1:0] bar_last;
	logic [COUNT_W-1:0] bar_count;
	logic bar_pulse;

	res_t pending_res[$];
	res_t want_res;
	int mismatches = 0;
	int items_sent = 0;
	int quiet_cycles = 0;
	bit steady = 1'b0;
	bit squeeze = 1'b0;
	bit squeeze_done = 1'b0;

	function automatic res_t res_of(logic sh, rc_t rc, mode_t ph, logic [SAMPLE_W-1:0] bl);
		res_t r;
		r.shutter = sh;
		r.remote_cmd = rc;
		r.phase = ph;
		r.baseline_out = bl;
		return r;
	endfunction

	function automatic void load_pulse();
		bar_mode = MODE_FIRE;
		bar_pulse = 1'b1;
		bar_count = {8'd0, cfg.pulse_ms};
	endfunction

	function automatic res_t step_barrier(cmd_t c, logic [SAMPLE_W-1:0] s);
		rc_t rc;
		int v;
		int b;
		int w;
		rc = RC_NONE;
		v = {22'd0, s};
		b = {22'd0, bar_base};
		w = {22'd0, cfg.window};
		case (c)
			CMD_ARM: begin
				if (bar_mode == MODE_IDLE) begin
					bar_mode = MODE_CAL;
					rc = RC_START;
				end
			end
			CMD_SAMPLE: begin
				if (bar_mode == MODE_CAL) begin
					if (s == bar_last) begin
						bar_base = s;
						bar_mode = MODE_ARMED;
					end
				end else if (bar_mode == MODE_ARMED && (v <= b - w || v >= b + w)) begin
					rc = RC_PAUSE;
					bar_count = {2'd0, cfg.trigger_delay_ms};
					if (bar_count == 0)
						load_pulse();
					else
						bar_mode = MODE_DELAY;
				end
				bar_last = s;
			end
			CMD_TICK: begin
				if (bar_mode == MODE_DELAY) begin
					if (bar_count > 1)
						bar_count--;
					else
						load_pulse();
				end else if (bar_mode == MODE_FIRE) begin
					if (bar_count > 1) begin
						bar_count--;
					end else if (bar_pulse) begin
						bar_pulse = 1'b0;
						bar_count = cfg.holdoff_ms;
						if (bar_count == 0) begin
							bar_mode = MODE_IDLE;
							rc = RC_STOP;
						end
					end else begin
						bar_count = '0;
						bar_mode = MODE_IDLE;
						rc = RC_STOP;
					end
				end
			end
			default: ;
		endcase
		return res_of(bar_pulse, rc, bar_mode, bar_base);
	endfunction

	function automatic stim_row_t reg_row(reg_idx_t i, logic [CFG_DATA_W-1:0] d);
		stim_row_t r;
		r.is_reg = 1'b1;
		r.idx = i;
		r.data = d;
		r.cmd = CMD_NOP;
		r.sample = '0;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t item_row(cmd_t c, logic [SAMPLE_W-1:0] s, bit typed = 1'b0,
			res_t want = '0);
		stim_row_t r;
		r.is_reg = 1'b0;
		r.idx = REG_WINDOW;
		r.data = '0;
		r.cmd = c;
		r.sample = s;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] clip10(int x);
		if (x < 0)
			return '0;
		if (x > 1023)
			return 10'd1023;
		return 10'(x);
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic offer_item(cmd_t c, logic [SAMPLE_W-1:0] s, bit typed = 1'b0,
			res_t want = '0);
		res_t got;
		while (!steady && $urandom_range(0, 99) < 18) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= c;
		in_ch.sample <= s;
		do
			@(posedge clk);
		while (!in_ch.ready);
		got = step_barrier(c, s);
		pending_res.push_back(typed ? want : got);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		in_ch.valid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		case (idx)
			REG_WINDOW: cfg.window = data[WINDOW_W-1:0];
			REG_DELAY: cfg.trigger_delay_ms = data[DELAY_W-1:0];
			REG_PULSE: cfg.pulse_ms = data[PULSE_W-1:0];
			REG_HOLDOFF: cfg.holdoff_ms = data[HOLDOFF_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic retune_regs();
		logic [WINDOW_W-1:0] win;
		logic [DELAY_W-1:0] dly;
		logic [PULSE_W-1:0] pw;
		logic [HOLDOFF_W-1:0] hold;
		case ($urandom_range(0, 5))
			0: win = '0;
			1: win = 10'd1023;
			2: win = 10'd1;
			default: win = 10'($urandom_range(2, 120));
		endcase
		case ($urandom_range(0, 7))
			0: dly = '0;
			1: dly = 14'($urandom_range(50, 200));
			default: dly = 14'($urandom_range(1, 12));
		endcase
		case ($urandom_range(0, 7))
			0: pw = '0;
			1: pw = 8'd255;
			2: pw = 8'd1;
			default: pw = 8'($urandom_range(2, 10));
		endcase
		case ($urandom_range(0, 7))
			0: hold = '0;
			1: hold = 16'($urandom_range(100, 400));
			default: hold = 16'($urandom_range(1, 15));
		endcase
		// Data bits above a register's width should be dropped by the block.
		write_reg(REG_WINDOW, {6'($urandom), win});
		write_reg(REG_DELAY, {2'($urandom), dly});
		write_reg(REG_PULSE, {8'($urandom), pw});
		write_reg(REG_HOLDOFF, hold);
	endtask

	task automatic run_out_timers(int bound);
		int n;
		n = 0;
		while ((bar_mode == MODE_DELAY || bar_mode == MODE_FIRE) && n < bound) begin
			if ($urandom_range(0, 99) < 8)
				offer_item(cmd_t'(2'($urandom_range(1, 3))), 10'($urandom));
			else
				offer_item(CMD_TICK, 10'($urandom));
			n++;
		end
	endtask

	// One arm-calibrate-detect-fire cycle with random content, or plain noise.
	task automatic run_trial();
		int lvl;
		int w;
		int b;
		int n;
		int off;
		if ($urandom_range(0, 99) < 15) begin
			n = $urandom_range(4, 20);
			repeat (n) offer_item(cmd_t'(2'($urandom_range(0, 3))), 10'($urandom));
			return;
		end
		offer_item(CMD_ARM, 10'($urandom));
		lvl = $urandom_range(0, 1023);
		n = $urandom_range(0, 3);
		repeat (n) offer_item(CMD_SAMPLE, 10'($urandom));
		offer_item(CMD_SAMPLE, 10'(lvl));
		offer_item(CMD_SAMPLE, 10'(lvl));
		w = {22'd0, cfg.window};
		n = $urandom_range(0, 12);
		repeat (n) begin
			case ($urandom_range(0, 5))
				0: offer_item(CMD_TICK, 10'($urandom));
				1: offer_item(cmd_t'(2'($urandom_range(2, 3))), 10'($urandom));
				default: begin
					off = 0;
					if (w > 0)
						off = int'($urandom_range(0, 2 * w - 2)) - (w - 1);
					offer_item(CMD_SAMPLE, clip10({22'd0, bar_base} + off));
				end
			endcase
		end
		// Aim at the band edges or at the rails, picked at random.
		n = 0;
		while (bar_mode == MODE_ARMED && n < 4) begin
			b = {22'd0, bar_base};
			case ($urandom_range(0, 3))
				0: offer_item(CMD_SAMPLE, clip10(b - w));
				1: offer_item(CMD_SAMPLE, clip10(b + w));
				2: offer_item(CMD_SAMPLE, 10'd0);
				default: offer_item(CMD_SAMPLE, 10'd1023);
			endcase
			n++;
		end
		run_out_timers(4000);
	endtask

	// Results are compared at the rising edge, before the block's registers move.
	function automatic void note_field(string name, logic [15:0] want, logic [15:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_res.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing expected, expected none, got phase %0d",
					$time, out_ch.phase);
			end else begin
				want_res = pending_res.pop_front();
				note_field("shutter", 16'(want_res.shutter), 16'(out_ch.shutter));
				note_field("remote_cmd", 16'(want_res.remote_cmd), 16'(out_ch.remote_cmd));
				note_field("phase", 16'(want_res.phase), 16'(out_ch.phase));
				note_field("baseline_out", 16'(want_res.baseline_out), 16'(out_ch.baseline_out));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : result_sink
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			// One long hold-off so the block fills up and stalls its input.
			if (squeeze && !squeeze_done) begin
				squeeze_done = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_ch.ready <= steady || ($urandom_range(0, 99) >= 18);
		end
	end

	initial begin : stimulus
		stim_row_t plan[$];
		stim_row_t row;
		int rand_base;
		int done;
		int n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = REG_WINDOW;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_TICK;
		in_ch.sample = '0;
		cfg.window = WINDOW_RST;
		cfg.trigger_delay_ms = DELAY_RST;
		cfg.pulse_ms = PULSE_RST;
		cfg.holdoff_ms = HOLDOFF_RST;
		bar_mode = MODE_IDLE;
		bar_base = '0;
		bar_last = '0;
		bar_count = '0;
		bar_pulse = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// Short timers so a whole cycle fits in a few rows.
		plan.push_back(reg_row(REG_DELAY, 16'd2));
		plan.push_back(reg_row(REG_PULSE, 16'd1));
		plan.push_back(reg_row(REG_HOLDOFF, 16'd1));
		plan.push_back(item_row(CMD_TICK, 10'd0, 1'b1, res_of(1'b0, RC_NONE, MODE_IDLE, 10'd0)));
		plan.push_back(item_row(CMD_NOP, 10'd1023, 1'b1,
			res_of(1'b0, RC_NONE, MODE_IDLE, 10'd0)));
		plan.push_back(item_row(CMD_SAMPLE, 10'd1023, 1'b1,
			res_of(1'b0, RC_NONE, MODE_IDLE, 10'd0)));
		plan.push_back(item_row(CMD_ARM, 10'd0, 1'b1, res_of(1'b0, RC_START, MODE_CAL, 10'd0)));
		plan.push_back(item_row(CMD_ARM, 10'd0, 1'b1, res_of(1'b0, RC_NONE, MODE_CAL, 10'd0)));
		// The reading held from before the arm request settles calibration.
		plan.push_back(item_row(CMD_SAMPLE, 10'd1023, 1'b1,
			res_of(1'b0, RC_NONE, MODE_ARMED, 10'd1023)));
		plan.push_back(item_row(CMD_TICK, 10'd0));
		plan.push_back(item_row(CMD_SAMPLE, 10'd974));
		plan.push_back(item_row(CMD_SAMPLE, 10'd973));
		repeat (4) plan.push_back(item_row(CMD_TICK, 10'd0));
		// Zero window, delay, pulse and holdoff all at once.
		plan.push_back(reg_row(REG_WINDOW, 16'd0));
		plan.push_back(reg_row(REG_DELAY, 16'd0));
		plan.push_back(reg_row(REG_PULSE, 16'd0));
		plan.push_back(reg_row(REG_HOLDOFF, 16'd0));
		plan.push_back(item_row(CMD_ARM, 10'd0));
		plan.push_back(item_row(CMD_SAMPLE, 10'd0));
		plan.push_back(item_row(CMD_SAMPLE, 10'd0));
		plan.push_back(item_row(CMD_SAMPLE, 10'd0));
		plan.push_back(item_row(CMD_TICK, 10'd0));
		// Widest window: baseline minus window goes negative and must not wrap.
		plan.push_back(reg_row(REG_WINDOW, 16'd1023));
		plan.push_back(item_row(CMD_ARM, 10'd0));
		plan.push_back(item_row(CMD_SAMPLE, 10'd0));
		plan.push_back(item_row(CMD_SAMPLE, 10'd1022));
		plan.push_back(item_row(CMD_SAMPLE, 10'd1023));
		plan.push_back(item_row(CMD_TICK, 10'd0));

		foreach (plan[k]) begin
			row = plan[k];
			if (row.is_reg)
				write_reg(row.idx, row.data);
			else
				offer_item(row.cmd, row.sample, row.typed, row.want);
		end

		rand_base = items_sent;
		done = 0;
		while (done < 750) begin
			steady = (done >= 250 && done < 450);
			retune_regs();
			// Raised after the register writes so items keep coming during the hold-off.
			if (done >= 500)
				squeeze = 1'b1;
			n = $urandom_range(2, 5);
			repeat (n) run_trial();
			done = items_sent - rand_base;
		end
		steady = 1'b0;
		if (!squeeze) begin
			squeeze = 1'b1;
			run_trial();
		end

		// Wide data words for window, delay and pulse: the bits above each register's width are dropped.
		write_reg(REG_WINDOW, 16'hFFFF);
		write_reg(REG_DELAY, 16'hC003);
		write_reg(REG_PULSE, 16'hFFFF);
		write_reg(REG_HOLDOFF, 16'd40);
		if (bar_mode != MODE_IDLE)
			run_out_timers(1000);
		offer_item(CMD_ARM, 10'd0);
		offer_item(CMD_SAMPLE, 10'd0);
		offer_item(CMD_SAMPLE, 10'd0);
		offer_item(CMD_SAMPLE, 10'd1023);
		run_out_timers(1000);

		in_ch.valid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
